>>> rtl/core/mse_pkg.sv
package mse_pkg;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_LL      = 6'h30;
   localparam logic [5:0] OP_SC      = 6'h38;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MUL  = 6'h19;
   localparam logic [5:0] FN_DIV  = 6'h1A;
   localparam logic [5:0] FN_DIVU = 6'h1B;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLT  = 6'h2A;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   localparam logic [31:0] HALT_ADDR  = 32'hFFFF_FFFF;
   localparam logic [31:0] SP_RESET   = 32'h0100_0000;
   localparam logic [31:0] RA_RESET   = 32'hFFFF_FFFF;
   localparam logic [31:0] JUMP_MASK  = 32'hF000_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_instr;   // capture instruction word
      logic load_ops;     // capture register operands
      logic div_start;    // start the divider
      logic div_step;     // one quotient bit
      logic commit;       // write back and form the result item
      logic clear_step;   // clearing sweep of memory and registers
   } ctrl_type;

   typedef struct packed {
      logic is_div;
      logic div_last;
      logic clear_done;
   } stat_type;

endpackage

>>> rtl/core/mips_subset_instruction_executor.sv
// Sequential executor for a subset of the MIPS32 integer instructions.
// The req_ channel carries one instruction word per item (tdata[31:0]),
// fetched at the previous next_fetch_address (zero after reset).
// The rsp_ channel returns one item per instruction: the next fetch address,
// the register write made and a halt flag set when the address is all ones.
// rsp_tvalid rises once an accepted item has passed the register file read,
// operand capture, memory read and execute steps; div and divu with a
// nonzero divisor also pass through the one-bit-a-cycle divider.
// One instruction is executed at a time; the next item is accepted at the
// earliest in the cycle after a result is formed, so no new item is taken
// while one is still being executed.
// After reset the block sweeps the data memory and register file, one
// entry a cycle, and raises req_tready once both are cleared.
// A stalled receiver holds its result item; one more item is accepted and
// waits at its execute step, after which req_tready stays low.
module mips_subset_instruction_executor #(
   parameter int DATA_WORDS = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // instruction_word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_fetch_address[31:0], write_enable[32], write_register[37:33],
   // write_value[69:38], halted[70], zero fill [71]
   output logic [71:0]  rsp_tdata
);

   mse_pkg::ctrl_type ctrl;
   mse_pkg::stat_type stat;
   logic [31:0] res_next, res_val;
   logic        res_we, res_halt;
   logic [4:0]  res_reg;

   mse_control u_control (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .stat(stat), .ctrl(ctrl)
   );

   mse_datapath #(.DATA_WORDS(DATA_WORDS)) u_datapath (
      .clock(clock), .ctrl(ctrl), .stat(stat), .reset(reset),
      .instr(req_tdata),
      .res_next(res_next), .res_we(res_we), .res_reg(res_reg),
      .res_val(res_val), .res_halt(res_halt)
   );

   assign rsp_tdata = {1'b0, res_halt, res_val, res_reg, res_we, res_next};

endmodule

>>> rtl/core/mse_ram.sv
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mse_datapath.sv
module mse_datapath #(
   parameter int DATA_WORDS = 4096
) (
   input  logic               clock,
   input  mse_pkg::ctrl_type  ctrl,
   output mse_pkg::stat_type  stat,
   input  logic               reset,
   input  logic [31:0]        instr,
   output logic [31:0]        res_next,
   output logic               res_we,
   output logic [4:0]         res_reg,
   output logic [31:0]        res_val,
   output logic               res_halt
);

   localparam int AW = $clog2(DATA_WORDS);
   localparam int SW = (AW > 5) ? AW : 5;

   logic [31:0] instr_ff;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [31:0] a_ff, b_ff;
   logic [31:0] rf_a, rf_b;
   logic [SW:0] clr_ff;
   logic        clr_busy;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] zimm, simm, pc4, ea;
   assign op   = instr_ff[31:26];
   assign rs   = instr_ff[25:21];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sh   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign zimm = {16'h0, instr_ff[15:0]};
   assign simm = {{16{instr_ff[15]}}, instr_ff[15:0]};
   assign pc4  = pc_ff + 32'd4;
   assign ea   = a_ff + simm;

   // Register file: two reads at instruction-chosen addresses, so it lives in RAMs.
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;
   logic        wr_any;
   logic [4:0]  wreg;
   logic [31:0] wval;

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rs), .rd_data(rf_a)
   );
   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rt), .rd_data(rf_b)
   );

   // Data memory.
   logic          dm_we;
   logic [AW-1:0] dm_wa;
   logic [31:0]   dm_wd, dm_rd;
   logic [AW-1:0] ea_idx;
   logic          dm_we_eff;
   logic [31:0]   dm_wd_eff;
   assign ea_idx = ea[AW+1:2];

   mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock(clock), .wr_en(dm_we_eff), .wr_addr(dm_wa), .wr_data(dm_wd_eff),
      .rd_addr(ea_idx), .rd_data(dm_rd)
   );

   // Clearing sweep after reset covers both the data memory and the register file.
   assign clr_busy        = ctrl.clear_step;
   assign stat.clear_done = clr_ff[SW:0] >= (SW+1)'(DATA_WORDS - 1) &&
                            clr_ff[SW:0] >= (SW+1)'(31);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clr_busy) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Radix-2 restoring divider on magnitudes.
   logic [31:0] dq_ff, dr_ff, dd_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_q_ff, dneg_r_ff, dsign_ff;
   logic [32:0] dtrial;
   logic [31:0] ma, mb;
   assign ma = (dsign_ff && a_ff[31]) ? 32'h0 - a_ff : a_ff;
   assign mb = (dsign_ff && b_ff[31]) ? 32'h0 - b_ff : b_ff;
   assign dtrial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};
   assign stat.div_last = dcnt_ff == 6'd31;
   assign stat.is_div   = op == mse_pkg::OP_SPECIAL &&
                          (fn == mse_pkg::FN_DIV || fn == mse_pkg::FN_DIVU) && b_ff != 32'h0;

   always_ff @(posedge clock) begin
      if (ctrl.load_instr) begin
         instr_ff <= instr;
      end
      if (ctrl.load_ops) begin
         a_ff     <= rf_a;
         b_ff     <= rf_b;
         dsign_ff <= fn == mse_pkg::FN_DIV;
      end
      if (ctrl.div_start) begin
         dq_ff     <= ma;
         dr_ff     <= '0;
         dd_ff     <= mb;
         dcnt_ff   <= '0;
         dneg_q_ff <= dsign_ff && (a_ff[31] ^ b_ff[31]);
         dneg_r_ff <= dsign_ff && a_ff[31];
      end else if (ctrl.div_step) begin
         if (!dtrial[32]) begin
            dr_ff <= dtrial[31:0];
            dq_ff <= {dq_ff[30:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[30:0], dq_ff[31]};
            dq_ff <= {dq_ff[30:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   logic [63:0] prod;
   assign prod = a_ff * b_ff;

   // Execute and write back.
   always_comb begin
      pc_in  = pc4;
      wr_any = 1'b0;
      wreg   = rt;
      wval   = '0;
      dm_we  = 1'b0;
      dm_wd  = b_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      if (op == mse_pkg::OP_SPECIAL) begin
         wreg   = rd;
         wr_any = 1'b1;
         case (fn)
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wval = a_ff + b_ff;
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval = a_ff - b_ff;
            mse_pkg::FN_AND:  wval = a_ff & b_ff;
            mse_pkg::FN_OR:   wval = a_ff | b_ff;
            mse_pkg::FN_NOR:  wval = ~(a_ff | b_ff);
            mse_pkg::FN_SLT:  wval = {31'h0, $signed(a_ff) < $signed(b_ff)};
            mse_pkg::FN_SLTU: wval = {31'h0, a_ff < b_ff};
            mse_pkg::FN_SLL:  wval = b_ff << sh;
            mse_pkg::FN_SRL:  wval = b_ff >> sh;
            mse_pkg::FN_MUL:  wval = prod[31:0];
            mse_pkg::FN_DIV, mse_pkg::FN_DIVU: begin
               wr_any = 1'b0;
               if (b_ff != 32'h0) begin
                  lo_in = dneg_q_ff ? 32'h0 - dq_ff : dq_ff;
                  hi_in = dneg_r_ff ? 32'h0 - dr_ff : dr_ff;
               end
            end
            mse_pkg::FN_JR: begin
               wr_any = 1'b0;
               pc_in  = a_ff;
            end
            default: wr_any = 1'b0;
         endcase
      end else begin
         case (op)
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr_any = 1'b1; wval = ea; end
            mse_pkg::OP_SLTI: begin
               wr_any = 1'b1;
               wval   = {31'h0, $signed(a_ff) < $signed(simm)};
            end
            mse_pkg::OP_SLTIU: begin wr_any = 1'b1; wval = {31'h0, a_ff < simm}; end
            mse_pkg::OP_ANDI: begin wr_any = 1'b1; wval = a_ff & zimm; end
            mse_pkg::OP_ORI:  begin wr_any = 1'b1; wval = a_ff | zimm; end
            mse_pkg::OP_LUI:  begin wr_any = 1'b1; wval = {instr_ff[15:0], 16'h0}; end
            mse_pkg::OP_BEQ: if (a_ff == b_ff) pc_in = pc4 + {simm[29:0], 2'b00};
            mse_pkg::OP_BNE: if (a_ff != b_ff) pc_in = pc4 + {simm[29:0], 2'b00};
            mse_pkg::OP_LW, mse_pkg::OP_LL: begin wr_any = 1'b1; wval = dm_rd; end
            mse_pkg::OP_LBU: begin wr_any = 1'b1; wval = {24'h0, dm_rd[7:0]}; end
            mse_pkg::OP_LHU: begin wr_any = 1'b1; wval = {16'h0, dm_rd[15:0]}; end
            mse_pkg::OP_SB: begin dm_we = 1'b1; dm_wd = {24'h0, b_ff[7:0]}; end
            mse_pkg::OP_SH: begin dm_we = 1'b1; dm_wd = {16'h0, b_ff[15:0]}; end
            mse_pkg::OP_SW: dm_we = 1'b1;
            mse_pkg::OP_SC: begin dm_we = 1'b1; wr_any = 1'b1; wval = 32'd1; end
            mse_pkg::OP_J:  pc_in = (pc4 & mse_pkg::JUMP_MASK) | {4'h0, instr_ff[25:0], 2'b00};
            mse_pkg::OP_JAL: begin
               pc_in  = (pc4 & mse_pkg::JUMP_MASK) | {4'h0, instr_ff[25:0], 2'b00};
               wr_any = 1'b1;
               wreg   = 5'd31;
               wval   = pc4;
            end
            default: wr_any = 1'b0;
         endcase
      end
      if (!wr_any || wreg == 5'd0) begin
         wr_any = 1'b0;
         wreg   = 5'd0;
         wval   = '0;
      end
   end

   // Register file and memory write ports are shared with the clearing sweep.
   always_comb begin
      if (clr_busy) begin
         rf_we = 1'b1;
         rf_wa = clr_ff[4:0];
         case (clr_ff[4:0])
            5'd29:   rf_wd = mse_pkg::SP_RESET;
            5'd31:   rf_wd = mse_pkg::RA_RESET;
            default: rf_wd = '0;
         endcase
         if (clr_ff > (SW+1)'(31)) begin
            rf_we = 1'b0;
         end
         dm_wa = clr_ff[AW-1:0];
      end else begin
         rf_we = ctrl.commit && wr_any;
         rf_wa = wreg;
         rf_wd = wval;
         dm_wa = ea_idx;
      end
   end

   assign dm_we_eff = clr_busy ? (clr_ff < (SW+1)'(DATA_WORDS)) : (ctrl.commit && dm_we);
   assign dm_wd_eff = clr_busy ? 32'h0 : dm_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (ctrl.commit) begin
         pc_ff    <= pc_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         res_next <= pc_in;
         res_we   <= wr_any;
         res_reg  <= wreg;
         res_val  <= wval;
         res_halt <= pc_in == mse_pkg::HALT_ADDR;
      end
   end

endmodule

>>> rtl/core/mse_control.sv
module mse_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  mse_pkg::stat_type stat,
   output mse_pkg::ctrl_type ctrl
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_DECODE = 7'b0001000,
      ST_MEM    = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_EXEC   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // A waiting result does not block the next item; that item holds in
   // ST_EXEC until the result register is free.
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      ctrl         = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               ctrl.load_instr = 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: state_in = ST_DECODE;
         ST_DECODE: begin
            ctrl.load_ops = 1'b1;
            state_in      = ST_MEM;
         end
         ST_MEM: begin
            if (stat.is_div) begin
               ctrl.div_start = 1'b1;
               state_in       = ST_DIV;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!out_valid_ff || rsp_tready) begin
               ctrl.commit  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> sim/tb_mips_subset_instruction_executor.sv
`timescale 1ns / 1ps

module tb_mips_subset_instruction_executor;

   localparam int MEM_WORDS = 4096;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        halted;
      logic [31:0] write_value;
      logic [4:0]  write_register;
      logic        write_enable;
      logic [31:0] next_fetch_address;
   } exec_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   // Shadow architectural state of the core.
   logic [31:0] model_pc;
   logic [31:0] model_gpr [32];
   logic [31:0] model_hi;
   logic [31:0] model_lo;
   logic [31:0] model_mem [MEM_WORDS];

   exec_result_type pending_results[$];
   int unsigned  mismatch_count;
   int unsigned  results_seen;
   int unsigned  items_sent;
   int unsigned  idle_cycles;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  hold_off_cycles;
   bit           timed_out;

   mips_subset_instruction_executor #(.DATA_WORDS(MEM_WORDS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit less_signed(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [31:0] word_addr(logic [31:0] addr);
      return (addr >> 2) % MEM_WORDS;
   endfunction

   task automatic execute_instruction(input logic [31:0] iw);
      logic [5:0]  op;
      logic [4:0]  rs, rt, rd, sa;
      logic [5:0]  fn;
      logic [31:0] zimm, simm, a, b, pc4, next, ea, wval, ma, mb, q, r;
      logic [63:0] prod;
      logic [4:0]  wreg;
      bit          wr;
      exec_result_type res;
      op = iw[31:26];
      rs = iw[25:21];
      rt = iw[20:16];
      rd = iw[15:11];
      sa = iw[10:6];
      fn = iw[5:0];
      zimm = {16'h0, iw[15:0]};
      simm = {{16{iw[15]}}, iw[15:0]};
      a = model_gpr[rs];
      b = model_gpr[rt];
      pc4 = model_pc + 32'd4;
      next = pc4;
      ea = a + simm;
      wr = 1'b0;
      wreg = 5'd0;
      wval = 32'd0;
      if (op == mse_pkg::OP_SPECIAL) begin
         wreg = rd;
         wr = 1'b1;
         case (fn)
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wval = a + b;
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval = a - b;
            mse_pkg::FN_AND: wval = a & b;
            mse_pkg::FN_OR:  wval = a | b;
            mse_pkg::FN_NOR: wval = ~(a | b);
            mse_pkg::FN_SLT: wval = less_signed(a, b) ? 32'd1 : 32'd0;
            mse_pkg::FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
            mse_pkg::FN_SLL: wval = b << sa;
            mse_pkg::FN_SRL: wval = b >> sa;
            mse_pkg::FN_MUL: begin
               prod = a * b;
               wval = prod[31:0];
            end
            mse_pkg::FN_DIV: begin
               wr = 1'b0;
               if (b != 0) begin
                  if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
                     model_lo = 32'h8000_0000;
                     model_hi = 32'd0;
                  end else begin
                     ma = a[31] ? -a : a;
                     mb = b[31] ? -b : b;
                     q = ma / mb;
                     r = ma % mb;
                     model_lo = (a[31] ^ b[31]) ? -q : q;
                     model_hi = a[31] ? -r : r;
                  end
               end
            end
            mse_pkg::FN_DIVU: begin
               wr = 1'b0;
               if (b != 0) begin
                  model_lo = a / b;
                  model_hi = a % b;
               end
            end
            mse_pkg::FN_JR: begin
               wr = 1'b0;
               next = a;
            end
            default: wr = 1'b0;
         endcase
      end else begin
         wreg = rt;
         case (op)
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr = 1'b1; wval = ea; end
            mse_pkg::OP_SLTI: begin
               wr = 1'b1;
               wval = less_signed(a, simm) ? 32'd1 : 32'd0;
            end
            mse_pkg::OP_SLTIU: begin wr = 1'b1; wval = (a < simm) ? 32'd1 : 32'd0; end
            mse_pkg::OP_ANDI: begin wr = 1'b1; wval = a & zimm; end
            mse_pkg::OP_ORI: begin wr = 1'b1; wval = a | zimm; end
            mse_pkg::OP_LUI: begin wr = 1'b1; wval = zimm << 16; end
            mse_pkg::OP_BEQ: if (a == b) next = pc4 + (simm << 2);
            mse_pkg::OP_BNE: if (a != b) next = pc4 + (simm << 2);
            mse_pkg::OP_LW, mse_pkg::OP_LL: begin
               wr = 1'b1;
               wval = model_mem[word_addr(ea)];
            end
            mse_pkg::OP_LBU: begin wr = 1'b1; wval = model_mem[word_addr(ea)] & 32'hFF; end
            mse_pkg::OP_LHU: begin wr = 1'b1; wval = model_mem[word_addr(ea)] & 32'hFFFF; end
            mse_pkg::OP_SB: model_mem[word_addr(ea)] = b & 32'hFF;
            mse_pkg::OP_SH: model_mem[word_addr(ea)] = b & 32'hFFFF;
            mse_pkg::OP_SW: model_mem[word_addr(ea)] = b;
            mse_pkg::OP_SC: begin
               model_mem[word_addr(ea)] = b;
               wr = 1'b1;
               wval = 32'd1;
            end
            mse_pkg::OP_J: next = (pc4 & mse_pkg::JUMP_MASK) | {4'h0, iw[25:0], 2'b00};
            mse_pkg::OP_JAL: begin
               next = (pc4 & mse_pkg::JUMP_MASK) | {4'h0, iw[25:0], 2'b00};
               wr = 1'b1;
               wreg = 5'd31;
               wval = pc4;
            end
            default: ;
         endcase
      end
      if (wr && wreg != 0) begin
         model_gpr[wreg] = wval;
      end else begin
         wr = 1'b0;
         wreg = 5'd0;
         wval = 32'd0;
      end
      model_pc = next;
      res.next_fetch_address = next;
      res.write_enable = wr;
      res.write_register = wreg;
      res.write_value = wval;
      res.halted = (next == mse_pkg::HALT_ADDR);
      pending_results.push_back(res);
   endtask

   // The valid line is dropped only when the sender idles or the stream ends,
   // so back-to-back items keep it high.
   task automatic send_instruction(input logic [31:0] iw);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= iw;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      execute_instruction(iw);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sa);
      return {mse_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // Register choice biased toward a few registers so results feed later items.
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 6));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(3))
         0: return 16'($urandom_range(0, 15) << 2);
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [5:0] fns [15];
      logic [5:0] ops [19];
      fns = '{mse_pkg::FN_ADD, mse_pkg::FN_ADDU, mse_pkg::FN_SUB, mse_pkg::FN_SUBU,
              mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_NOR, mse_pkg::FN_SLT,
              mse_pkg::FN_SLTU, mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_MUL,
              mse_pkg::FN_DIV, mse_pkg::FN_DIVU, mse_pkg::FN_JR};
      ops = '{mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTI, mse_pkg::OP_SLTIU,
              mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_LUI, mse_pkg::OP_BEQ,
              mse_pkg::OP_BNE, mse_pkg::OP_LW, mse_pkg::OP_LBU, mse_pkg::OP_LHU,
              mse_pkg::OP_LL, mse_pkg::OP_SB, mse_pkg::OP_SH, mse_pkg::OP_SW,
              mse_pkg::OP_SC, mse_pkg::OP_J, mse_pkg::OP_JAL};
      case ($urandom_range(19))
         0: return $urandom;
         1, 2, 3, 4, 5, 6, 7, 8:
            return enc_r(fns[$urandom_range(14)], pick_reg(), pick_reg(), pick_reg(),
                         5'($urandom));
         default:
            if ($urandom_range(1)) begin
               return {ops[$urandom_range(18)], pick_reg(), pick_reg(), pick_imm()};
            end else begin
               return {ops[$urandom_range(18)], 26'($urandom)};
            end
      endcase
   endfunction

   task automatic test_directed();
      send_instruction(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
      send_instruction(enc_i(mse_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
      send_instruction(enc_r(mse_pkg::FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_SUB, 5'd1, 5'd31, 5'd4, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_SLT, 5'd1, 5'd2, 5'd5, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_SLTU, 5'd1, 5'd2, 5'd6, 5'd0));
      send_instruction(enc_i(mse_pkg::OP_SLTIU, 5'd0, 5'd7, 16'hFFFF));
      send_instruction(enc_i(mse_pkg::OP_ANDI, 5'd2, 5'd8, 16'hFFFF));
      send_instruction(enc_r(mse_pkg::FN_SRL, 5'd0, 5'd2, 5'd9, 5'd31));
      send_instruction(enc_r(mse_pkg::FN_SLL, 5'd0, 5'd2, 5'd9, 5'd31));
      send_instruction(enc_r(mse_pkg::FN_MUL, 5'd2, 5'd2, 5'd10, 5'd0));
      // Signed overflow divide, then divide by zero must keep HI and LO.
      send_instruction(enc_r(mse_pkg::FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_DIV, 5'd2, 5'd29, 5'd0, 5'd0));
      send_instruction(enc_r(mse_pkg::FN_ADD, 5'd2, 5'd2, 5'd0, 5'd0));
      send_instruction(enc_i(mse_pkg::OP_SW, 5'd29, 5'd2, 16'hFFFC));
      send_instruction(enc_i(mse_pkg::OP_LBU, 5'd29, 5'd11, 16'hFFFD));
      send_instruction(enc_i(mse_pkg::OP_LHU, 5'd29, 5'd11, 16'hFFFC));
      send_instruction(enc_i(mse_pkg::OP_SC, 5'd1, 5'd2, 16'h7FFC));
      send_instruction(enc_i(mse_pkg::OP_LL, 5'd1, 5'd12, 16'h7FFC));
      send_instruction(enc_i(mse_pkg::OP_BNE, 5'd1, 5'd2, 16'h8000));
      send_instruction(enc_i(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'h7FFF));
      send_instruction({mse_pkg::OP_JAL, 26'h3FF_FFFF});
      send_instruction({6'h20, 26'h3FF_FFFF});
      // Jump back through the link register that the JAL above wrote.
      send_instruction(enc_r(mse_pkg::FN_JR, 5'd31, 5'd0, 5'd0, 5'd0));
   endtask

   task automatic test_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         send_instruction(random_instruction());
      end
   endtask

   task automatic test_back_pressure();
      wait_drained();
      hold_off_cycles = 300;
      for (int n = 0; n < 20; n++) begin
         send_instruction(random_instruction());
      end
      wait_drained();
   endtask

   // Result side: random stalls, optional long hold-off, and checking.
   always @(posedge clock) begin
      exec_result_type got;
      exec_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = exec_result_type'(rsp_tdata[70:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected item: %h", rsp_tdata);
               end
            end else begin
               want = pending_results.pop_front();
               if (got !== want || rsp_tdata[71] !== 1'b0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: next %h/%h we %b/%b reg %0d/%0d val %h/%h halt %b/%b",
                              want.next_fetch_address, got.next_fetch_address,
                              want.write_enable, got.write_enable,
                              want.write_register, got.write_register,
                              want.write_value, got.write_value, want.halted, got.halted);
                  end
               end
            end
         end
         if (hold_off_cycles != 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      mismatch_count = 0;
      results_seen = 0;
      items_sent = 0;
      idle_cycles = 0;
      hold_off_cycles = 0;
      timed_out = 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 62;
      model_pc = '0;
      model_hi = '0;
      model_lo = '0;
      foreach (model_gpr[k]) model_gpr[k] = '0;
      model_gpr[29] = mse_pkg::SP_RESET;
      model_gpr[31] = mse_pkg::RA_RESET;
      foreach (model_mem[k]) model_mem[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(500);
      send_idle_pct = 62;
      recv_idle_pct = 8;
      test_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_back_pressure();
      test_random(550);
      wait_drained();
      repeat (60) @(posedge clock);
      $display("Ran %0d instructions covering every supported opcode, random words,",
               items_sent);
      $display("stalls on both sides and a long result hold-off; %0d results checked.",
               results_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> mips_subset_instruction_executor.f
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/mse_datapath.sv
rtl/core/mse_control.sv
rtl/core/mips_subset_instruction_executor.sv
sim/tb_mips_subset_instruction_executor.sv
